>>> design/bgauge_pkg.sv
// ----------------------------------------------------------------------------
// bgauge_pkg
// Shared types and constants of the battery gauge: field widths, percent
// constants, register indexes and reset voltages.
// ----------------------------------------------------------------------------
package bgauge_pkg;

  localparam int unsigned MV_W      = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned NUM_PTS   = 5;
  // (mv - lo) * 25 stays below 65536 * 25 < 2^21
  localparam int unsigned PROD_W    = 21;
  // quotient of one interpolation segment is below 25
  localparam int unsigned QPCT_W    = 5;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [MV_W-1:0]  MV_SAT   = 16'hFFFF;
  localparam logic [PCT_W-1:0] STEP_PCT = 7'd25;
  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_EMPTY         = 3'd0,
    REG_QUARTER       = 3'd1,
    REG_HALF          = 3'd2,
    REG_THREE_QUARTER = 3'd3,
    REG_FULL          = 3'd4
  } cfg_reg_e;

  typedef logic [MV_W-1:0] mv_t;
  typedef mv_t [NUM_PTS-1:0] volt_set_t;

  typedef struct packed {
    mv_t  mv;
    logic bad;
  } volt_item_t;

  localparam volt_set_t VOLT_RESET = {16'd4200, 16'd3760, 16'd3630, 16'd3500, 16'd3200};

endpackage

>>> design/bgauge_recip_div.sv
// ----------------------------------------------------------------------------
// bgauge_recip_div
// Pipelined restoring divider: supply mV = floor(1100 * (2^ADC_BITS - 1) / code),
// one quotient bit per stage, saturated to 16 bits at the output.
// ----------------------------------------------------------------------------
module bgauge_recip_div #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ADC_BITS-1:0]    code_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bgauge_pkg::volt_item_t out_item_o
);
  import bgauge_pkg::*;

  localparam int unsigned NUMER = 1100 * ((32'd1 << ADC_BITS) - 32'd1);
  localparam int unsigned NUM_W = $clog2(NUMER + 1);
  localparam logic [NUM_W-1:0] NUMER_V = NUM_W'(NUMER);

  logic                v_q    [NUM_W];
  logic                en     [NUM_W];
  logic [ADC_BITS-1:0] code_q [NUM_W];
  logic [ADC_BITS-1:0] rem_q  [NUM_W];
  logic [NUM_W-1:0]    quo_q  [NUM_W];
  logic                bad_q  [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic                vin;
    logic [ADC_BITS-1:0] code_in;
    logic [ADC_BITS-1:0] rem_in;
    logic [NUM_W-1:0]    quo_in;
    logic                bad_in;
    logic [ADC_BITS:0]   trial;
    logic [ADC_BITS:0]   diff;
    logic                take;
    logic [ADC_BITS-1:0] rem_d;
    logic [NUM_W-1:0]    quo_d;

    if (s == 0) begin : g_head
      assign vin     = in_valid_i;
      assign code_in = code_i;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign bad_in  = (code_i == '0);
    end else begin : g_body
      assign vin     = v_q[s-1];
      assign code_in = code_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign bad_in  = bad_q[s-1];
    end

    // advance into an empty stage, or when the next stage moves on
    if (s == NUM_W - 1) begin : g_tail_en
      assign en[s] = !v_q[s] || !out_stall_i;
    end else begin : g_mid_en
      assign en[s] = !v_q[s] || en[s+1];
    end

    assign trial = {rem_in, NUMER_V[NUM_W-1-s]};
    assign diff  = trial - {1'b0, code_in};
    assign take  = (trial >= {1'b0, code_in});
    assign rem_d = take ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
    assign quo_d = {quo_in[NUM_W-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && vin) begin
        code_q[s] <= code_in;
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        bad_q[s]  <= bad_in;
      end
    end
  end

  assign in_stall_o     = !en[0];
  assign out_valid_o    = v_q[NUM_W-1];
  assign out_item_o.mv  = (|quo_q[NUM_W-1][NUM_W-1:MV_W]) ? MV_SAT
                                                          : quo_q[NUM_W-1][MV_W-1:0];
  assign out_item_o.bad = bad_q[NUM_W-1];

endmodule

>>> design/bgauge_interp.sv
// ----------------------------------------------------------------------------
// bgauge_interp
// Piecewise-linear charge estimate: breakpoint compare, segment select,
// multiply by 25, five-stage restoring divide, final add and clamp.
// ----------------------------------------------------------------------------
module bgauge_interp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bgauge_pkg::volt_item_t     in_item_i,
  input  bgauge_pkg::volt_set_t      volts_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                supply_mv_o,
  output logic [6:0]                 charge_percent_o,
  output logic                       bad_reading_o
);
  import bgauge_pkg::*;

  localparam int unsigned DIV0  = 3;
  localparam int unsigned NSTG  = DIV0 + QPCT_W + 1;
  localparam int unsigned ST_OUT = NSTG - 1;

  logic v_q   [NSTG];
  logic en    [NSTG];
  mv_t  mv_q  [NSTG];
  logic bad_q [NSTG];

  // valid and pass-through fields for every stage
  for (genvar s = 0; s < NSTG; s++) begin : g_ctl
    logic vin;
    mv_t  mv_in;
    logic bad_in;

    if (s == 0) begin : g_head
      assign vin    = in_valid_i;
      assign mv_in  = in_item_i.mv;
      assign bad_in = in_item_i.bad;
    end else begin : g_body
      assign vin    = v_q[s-1];
      assign mv_in  = mv_q[s-1];
      assign bad_in = bad_q[s-1];
    end

    if (s == NSTG - 1) begin : g_tail_en
      assign en[s] = !v_q[s] || !out_stall_i;
    end else begin : g_mid_en
      assign en[s] = !v_q[s] || en[s+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && vin) begin
        mv_q[s]  <= mv_in;
        bad_q[s] <= bad_in;
      end
    end
  end

  // stage 0: compare against every breakpoint
  logic [NUM_PTS-1:0] lt_d, lt_q;

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      lt_d[i] = (in_item_i.mv < volts_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      lt_q <= lt_d;
    end
  end

  // stage 1: pick the first breakpoint above the voltage
  logic             zero1_d, full1_d, zero1_q, full1_q;
  logic [PCT_W-1:0] base1_d, base1_q;
  mv_t              lo1, hi1;
  mv_t              diff1_d, span1_d, diff1_q, span1_q;

  always_comb begin
    lo1     = volts_i[0];
    hi1     = volts_i[1];
    base1_d = '0;
    // descending scan so the lowest matching segment wins
    for (int k = NUM_PTS - 1; k >= 1; k--) begin
      if (lt_q[k]) begin
        lo1     = volts_i[k-1];
        hi1     = volts_i[k];
        base1_d = PCT_W'(STEP_PCT * (k - 1));
      end
    end
    zero1_d = lt_q[0] && !bad_q[0];
    full1_d = bad_q[0] || !lt_q[NUM_PTS-1];
    diff1_d = mv_q[0] - lo1;
    span1_d = hi1 - lo1;
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      zero1_q <= zero1_d;
      full1_q <= full1_d;
      base1_q <= base1_d;
      diff1_q <= diff1_d;
      span1_q <= span1_d;
    end
  end

  // stage 2: times 25 as shift-and-add
  logic [PROD_W-1:0] prod2_d, prod2_q;
  logic              zero2_q, full2_q;
  logic [PCT_W-1:0]  base2_q;
  mv_t               span2_q;

  assign prod2_d = (PROD_W'(diff1_q) << 4) + (PROD_W'(diff1_q) << 3) + PROD_W'(diff1_q);

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      prod2_q <= prod2_d;
      zero2_q <= zero1_q;
      full2_q <= full1_q;
      base2_q <= base1_q;
      span2_q <= span1_q;
    end
  end

  // stages 3..7: one quotient bit each
  logic [PROD_W-1:0] rem_q  [QPCT_W];
  logic [QPCT_W-1:0] quo_q  [QPCT_W];
  mv_t               span_q [QPCT_W];
  logic [PCT_W-1:0]  base_q [QPCT_W];
  logic              zero_q [QPCT_W];
  logic              full_q [QPCT_W];

  for (genvar j = 0; j < QPCT_W; j++) begin : g_div
    logic [PROD_W-1:0] rem_in;
    logic [QPCT_W-1:0] quo_in;
    mv_t               span_in;
    logic [PCT_W-1:0]  base_in;
    logic              zero_in, full_in;
    logic [PROD_W-1:0] sh;
    logic              take;
    logic [PROD_W-1:0] rem_d;
    logic [QPCT_W-1:0] quo_d;

    if (j == 0) begin : g_head
      assign rem_in  = prod2_q;
      assign quo_in  = '0;
      assign span_in = span2_q;
      assign base_in = base2_q;
      assign zero_in = zero2_q;
      assign full_in = full2_q;
    end else begin : g_body
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign span_in = span_q[j-1];
      assign base_in = base_q[j-1];
      assign zero_in = zero_q[j-1];
      assign full_in = full_q[j-1];
    end

    assign sh    = PROD_W'(span_in) << (QPCT_W - 1 - j);
    assign take  = (rem_in >= sh);
    assign rem_d = take ? (rem_in - sh) : rem_in;
    assign quo_d = {quo_in[QPCT_W-2:0], take};

    always_ff @(posedge clk_i) begin
      if (en[DIV0+j] && v_q[DIV0+j-1]) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        span_q[j] <= span_in;
        base_q[j] <= base_in;
        zero_q[j] <= zero_in;
        full_q[j] <= full_in;
      end
    end
  end

  // output stage: add segment base, apply clamps
  logic [PCT_W-1:0] pct_d, pct_q;

  always_comb begin
    if (zero_q[QPCT_W-1]) begin
      pct_d = '0;
    end else if (full_q[QPCT_W-1]) begin
      pct_d = FULL_PCT;
    end else begin
      pct_d = base_q[QPCT_W-1] + PCT_W'(quo_q[QPCT_W-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT] && v_q[ST_OUT-1]) begin
      pct_q <= pct_d;
    end
  end

  assign in_stall_o       = !en[0];
  assign out_valid_o      = v_q[ST_OUT];
  assign supply_mv_o      = mv_q[ST_OUT];
  assign charge_percent_o = pct_q;
  assign bad_reading_o    = bad_q[ST_OUT];

endmodule

>>> design/battery_gauge_from_bandgap_top.sv
// ----------------------------------------------------------------------------
// battery_gauge_from_bandgap_top
// Supply voltage and state of charge from a bandgap ADC reading, with five
// APB-programmable breakpoint voltages.
// ----------------------------------------------------------------------------
// Pipeline: ceil(log2(1100*(2^ADC_BITS-1)+1)) divider stages plus
//   9 gauge stages.
// Throughput: one item per cycle while out_stall_i is low; the reciprocal
//   divider retires one quotient bit per stage; a stage moves when empty or the next moves.
// Reset: empties the pipeline and loads the breakpoints with 3200, 3500,
//   3630, 3760 and 4200 mV.
module battery_gauge_from_bandgap_top #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ADC_BITS-1:0] adc_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         supply_mv_o,
  output logic [6:0]          charge_percent_o,
  output logic                bad_reading_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bgauge_pkg::*;

  volt_set_t              volt_d, volt_q;
  logic                   wr_en;
  cfg_reg_e               reg_idx;
  logic                   mid_valid, mid_stall;
  volt_item_t             mid_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = cfg_reg_e'(paddr[APB_AW-1:2]);

  always_comb begin
    volt_d = volt_q;
    if (wr_en) begin
      case (reg_idx)
        REG_EMPTY:         volt_d[0] = pwdata[MV_W-1:0];
        REG_QUARTER:       volt_d[1] = pwdata[MV_W-1:0];
        REG_HALF:          volt_d[2] = pwdata[MV_W-1:0];
        REG_THREE_QUARTER: volt_d[3] = pwdata[MV_W-1:0];
        REG_FULL:          volt_d[4] = pwdata[MV_W-1:0];
        default:           volt_d    = volt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_q <= VOLT_RESET;
    end else begin
      volt_q <= volt_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EMPTY:         prdata = {16'd0, volt_q[0]};
      REG_QUARTER:       prdata = {16'd0, volt_q[1]};
      REG_HALF:          prdata = {16'd0, volt_q[2]};
      REG_THREE_QUARTER: prdata = {16'd0, volt_q[3]};
      REG_FULL:          prdata = {16'd0, volt_q[4]};
      default:           prdata = '0;
    endcase
  end

  bgauge_recip_div #(
    .ADC_BITS (ADC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_i      (adc_code_i),
    .out_valid_o (mid_valid),
    .out_stall_i (mid_stall),
    .out_item_o  (mid_item)
  );

  bgauge_interp u_interp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (mid_valid),
    .in_stall_o       (mid_stall),
    .in_item_i        (mid_item),
    .volts_i          (volt_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .supply_mv_o      (supply_mv_o),
    .charge_percent_o (charge_percent_o),
    .bad_reading_o    (bad_reading_o)
  );

  // a zero code always reports a saturated supply and a full charge
  a_bad_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_reading_o |-> supply_mv_o == MV_SAT && charge_percent_o == FULL_PCT)
    else $error("bad reading without saturated outputs");

  // the input stalls only when a finished item is held at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while pipeline can drain");

  // nothing reaches the output right after reset is released
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule
